// ===== src/bvs_pkg.sv =====
// Package for the bitmap vocabulary shortlist selector.
// Holds sizes, action and status codes, payload structs and bitmap helpers.
// No dependencies.
package bvs_pkg;

  localparam int SRC_VOCAB    = 32768;
  localparam int TRG_VOCAB    = 32768;
  localparam int LIST_DEPTH   = 1048576;
  localparam int PAD_MULTIPLE = 8;
  localparam int PAD_W        = $clog2(PAD_MULTIPLE);

  localparam int WORD_W    = 32;
  localparam int WORD_AW   = $clog2(WORD_W);
  localparam int TGT_WORDS = TRG_VOCAB / WORD_W;
  localparam int SRC_WORDS = SRC_VOCAB / WORD_W;
  localparam int TW_AW     = $clog2(TGT_WORDS);
  localparam int SW_AW     = $clog2(SRC_WORDS);
  localparam int CLR_WORDS = (TGT_WORDS > SRC_WORDS) ? TGT_WORDS : SRC_WORDS;
  localparam int CLR_AW    = $clog2(CLR_WORDS);
  localparam int OFF_DEPTH = SRC_VOCAB + 1;
  localparam int OFF_AW    = $clog2(OFF_DEPTH);
  localparam int LIST_AW   = $clog2(LIST_DEPTH);
  localparam int POS_W     = $clog2(TRG_VOCAB) + 2;
  localparam int TIDX_W    = $clog2(TRG_VOCAB);

  localparam logic [2:0] ACT_LOAD_OFF  = 3'd0;
  localparam logic [2:0] ACT_LOAD_LIST = 3'd1;
  localparam logic [2:0] ACT_BEGIN     = 3'd2;
  localparam logic [2:0] ACT_SOURCE    = 3'd3;
  localparam logic [2:0] ACT_FINISH    = 3'd4;
  localparam logic [2:0] ACT_READ      = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SRC_OOR  = 2'd1;
  localparam logic [1:0] ST_NO_MORE  = 2'd2;
  localparam logic [1:0] ST_ADDR_OOR = 2'd3;

  localparam logic [7:0] CFG_FIRST_COUNT = 8'd0;
  localparam logic [7:0] CFG_SHARED_MODE = 8'd1;
  localparam logic [7:0] CFG_SRC_SIZE    = 8'd2;
  localparam logic [7:0] CFG_TRG_SIZE    = 8'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [19:0] table_address;
    logic [20:0] table_value;
    logic [14:0] source_word;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] selected_index;
    logic [15:0] selected_count;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] first_count;
    logic        shared_mode;
    logic [15:0] src_vocab_size;
    logic [15:0] trg_vocab_size;
  } cfg_t;

  function automatic logic [WORD_W-1:0] below_mask(logic [POS_W-1:0] base,
                                                   logic [POS_W-1:0] lim);
    logic [WORD_W-1:0] m;
    if (base + POS_W'(WORD_W) <= lim) begin
      m = {WORD_W{1'b1}};
    end else if (base >= lim) begin
      m = '0;
    end else begin
      m = ~({WORD_W{1'b1}} << lim[WORD_AW-1:0]);
    end
    return m;
  endfunction

  function automatic logic [WORD_W-1:0] mask_from(logic [WORD_AW-1:0] b);
    return {WORD_W{1'b1}} << b;
  endfunction

  function automatic logic [WORD_W-1:0] bit_at(logic [WORD_AW-1:0] b);
    return WORD_W'(1) << b;
  endfunction

  function automatic logic [WORD_AW-1:0] first_set(logic [WORD_W-1:0] m);
    logic [WORD_AW-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (m[i]) idx = WORD_AW'(i);
    end
    return idx;
  endfunction

endpackage

// ===== src/bvs_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
// Generic; used for the tables and bitmaps of the shortlist selector.
module bvs_ram #(
  parameter int W  = 32,
  parameter int D  = 1024,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bvs_seq.sv =====
// Sequencer of the shortlist selector: tables, bitmaps and the shared word unit.
// Depends on bvs_pkg and bvs_ram.
module bvs_seq (
  input  logic          clk,
  input  logic          rst,
  input  bvs_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_stall,
  input  bvs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bvs_pkg::out_t out_data
);
  import bvs_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_BEGIN    = 5'd1;
  localparam logic [4:0] S_SRC_CHK  = 5'd2;
  localparam logic [4:0] S_OFF_A    = 5'd3;
  localparam logic [4:0] S_OFF_B    = 5'd4;
  localparam logic [4:0] S_WALK     = 5'd5;
  localparam logic [4:0] S_LIST_CHK = 5'd6;
  localparam logic [4:0] S_TGT_UPD  = 5'd7;
  localparam logic [4:0] S_CNT_RD   = 5'd8;
  localparam logic [4:0] S_CNT_ACC  = 5'd9;
  localparam logic [4:0] S_PAD_GO   = 5'd10;
  localparam logic [4:0] S_PAD_RD   = 5'd11;
  localparam logic [4:0] S_PAD_CHK  = 5'd12;
  localparam logic [4:0] S_SCAN     = 5'd13;
  localparam logic [4:0] S_SCAN_CHK = 5'd14;
  localparam logic [4:0] S_DONE     = 5'd15;

  logic [4:0]         state;
  logic               clr;
  logic [CLR_AW:0]    sweep;
  in_t                item;
  logic [20:0]        j;
  logic [20:0]        lend;
  logic [TW_AW-1:0]   tw;
  logic [WORD_AW-1:0] tbit;
  logic [15:0]        ones;
  logic [PAD_W-1:0]   need;
  logic [POS_W-1:0]   pos;
  logic               phase;
  logic [TIDX_W-1:0]  kfound;
  logic [15:0]        sel_total;
  logic [15:0]        cursor;
  out_t               res;
  out_t               res_init;

  logic               tgt_we, seen_we, off_we, list_we;
  logic [TW_AW-1:0]   tgt_wa, tgt_ra;
  logic [WORD_W-1:0]  tgt_wd, tgt_rd;
  logic [SW_AW-1:0]   seen_wa, seen_ra;
  logic [WORD_W-1:0]  seen_wd, seen_rd;
  logic [OFF_AW-1:0]  off_ra;
  logic [20:0]        off_rd;
  logic [LIST_AW-1:0] list_ra;
  logic [14:0]        list_rd;

  logic               accept;
  logic [15:0]        tn, srcuse, lim;
  logic [POS_W-1:0]   tn_p;
  logic [WORD_W-1:0]  bm_tw, elig, scan_m;
  logic [WORD_AW-1:0] elig_b, scan_b;
  logic [14:0]        src;
  logic [POS_W-1:0]   sweep_base;

  bvs_ram #(.W(WORD_W), .D(TGT_WORDS)) u_tgt (
    .clk(clk), .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd), .raddr(tgt_ra), .rdata(tgt_rd)
  );
  bvs_ram #(.W(WORD_W), .D(SRC_WORDS)) u_seen (
    .clk(clk), .we(seen_we), .waddr(seen_wa), .wdata(seen_wd), .raddr(seen_ra),
    .rdata(seen_rd)
  );
  bvs_ram #(.W(21), .D(OFF_DEPTH)) u_off (
    .clk(clk), .we(off_we), .waddr(in_data.table_address[OFF_AW-1:0]),
    .wdata(in_data.table_value), .raddr(off_ra), .rdata(off_rd)
  );
  bvs_ram #(.W(15), .D(LIST_DEPTH)) u_list (
    .clk(clk), .we(list_we), .waddr(in_data.table_address[LIST_AW-1:0]),
    .wdata(in_data.table_value[14:0]), .raddr(list_ra), .rdata(list_rd)
  );

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign tn         = (cfg.trg_vocab_size > 16'(TRG_VOCAB)) ? 16'(TRG_VOCAB)
                                                           : cfg.trg_vocab_size;
  assign srcuse     = (cfg.src_vocab_size > 16'(SRC_VOCAB)) ? 16'(SRC_VOCAB)
                                                           : cfg.src_vocab_size;
  assign lim        = (cfg.first_count < tn) ? cfg.first_count : tn;
  assign tn_p       = POS_W'(tn);
  assign src        = item.source_word;
  assign sweep_base = POS_W'({sweep, WORD_AW'(0)});
  assign bm_tw      = below_mask(POS_W'({tw, WORD_AW'(0)}), tn_p);
  assign elig       = ~tgt_rd & mask_from(pos[WORD_AW-1:0]) & bm_tw;
  assign scan_m     = tgt_rd & mask_from(pos[WORD_AW-1:0]) & bm_tw;
  assign elig_b     = first_set(elig);
  assign scan_b     = first_set(scan_m);

  always_comb begin
    res_init = '0;
    case (in_data.action)
      ACT_LOAD_OFF: begin
        if (21'(in_data.table_address) >= 21'(OFF_DEPTH)) res_init.status = ST_ADDR_OOR;
      end
      ACT_LOAD_LIST: begin
        if (25'(in_data.table_address) >= 25'(LIST_DEPTH) ||
            in_data.table_value >= 21'(TRG_VOCAB)) res_init.status = ST_ADDR_OOR;
      end
      ACT_SOURCE: begin
        if (16'(in_data.source_word) >= srcuse) res_init.status = ST_SRC_OOR;
      end
      default: ;
    endcase
  end

  always_comb begin
    tgt_we  = 1'b0;
    tgt_wa  = tw;
    tgt_wd  = tgt_rd | bit_at(tbit);
    tgt_ra  = tw;
    seen_we = 1'b0;
    seen_wa = src[WORD_AW+SW_AW-1:WORD_AW];
    seen_wd = seen_rd | bit_at(src[WORD_AW-1:0]);
    seen_ra = src[WORD_AW+SW_AW-1:WORD_AW];
    off_we  = 1'b0;
    list_we = 1'b0;
    off_ra  = OFF_AW'(src);
    list_ra = j[LIST_AW-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          tgt_ra  = in_data.source_word[WORD_AW+TW_AW-1:WORD_AW];
          seen_ra = in_data.source_word[WORD_AW+SW_AW-1:WORD_AW];
          off_we  = (in_data.action == ACT_LOAD_OFF) &&
                    (21'(in_data.table_address) < 21'(OFF_DEPTH));
          list_we = (in_data.action == ACT_LOAD_LIST) &&
                    (25'(in_data.table_address) < 25'(LIST_DEPTH)) &&
                    (in_data.table_value < 21'(TRG_VOCAB));
        end
      end
      S_BEGIN: begin
        tgt_we  = (sweep < (CLR_AW+1)'(TGT_WORDS));
        tgt_wa  = sweep[TW_AW-1:0];
        tgt_wd  = below_mask(sweep_base, clr ? '0 : POS_W'(lim));
        seen_we = (sweep < (CLR_AW+1)'(SRC_WORDS));
        seen_wa = sweep[SW_AW-1:0];
        seen_wd = '0;
      end
      S_SRC_CHK: begin
        tgt_we  = cfg.shared_mode && (16'(src) < tn);
        tgt_wa  = src[WORD_AW+TW_AW-1:WORD_AW];
        tgt_wd  = tgt_rd | bit_at(src[WORD_AW-1:0]);
        seen_we = !seen_rd[src[WORD_AW-1:0]];
      end
      S_OFF_A:    off_ra = OFF_AW'(src) + OFF_AW'(1);
      S_LIST_CHK: tgt_ra = list_rd[WORD_AW+TW_AW-1:WORD_AW];
      S_TGT_UPD:  tgt_we = 1'b1;
      S_CNT_RD:   tgt_ra = sweep[TW_AW-1:0];
      S_PAD_RD:   tgt_ra = pos[WORD_AW+TW_AW-1:WORD_AW];
      S_SCAN:     tgt_ra = pos[WORD_AW+TW_AW-1:WORD_AW];
      S_PAD_CHK: begin
        tgt_we = (elig != '0);
        tgt_wd = tgt_rd | bit_at(elig_b);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BEGIN;
      clr       <= 1'b1;
      sweep     <= '0;
      sel_total <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            item <= in_data;
            res  <= res_init;
            case (in_data.action)
              ACT_BEGIN: begin
                clr   <= 1'b0;
                sweep <= '0;
                state <= S_BEGIN;
              end
              ACT_SOURCE: begin
                if (res_init.status == ST_SRC_OOR) state <= S_DONE;
                else state <= S_SRC_CHK;
              end
              ACT_FINISH: begin
                ones  <= '0;
                sweep <= '0;
                state <= S_CNT_RD;
              end
              ACT_READ: begin
                pos   <= POS_W'(cursor);
                phase <= 1'b0;
                state <= S_SCAN;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_BEGIN: begin
          sweep <= sweep + (CLR_AW+1)'(1);
          if (sweep == (CLR_AW+1)'(CLR_WORDS - 1)) begin
            if (clr) begin
              state <= S_IDLE;
            end else begin
              sel_total <= '0;
              cursor    <= '0;
              state     <= S_DONE;
            end
            clr <= 1'b0;
          end
        end
        S_SRC_CHK: begin
          if (seen_rd[src[WORD_AW-1:0]]) state <= S_DONE;
          else state <= S_OFF_A;
        end
        S_OFF_A: begin
          j     <= off_rd;
          state <= S_OFF_B;
        end
        S_OFF_B: begin
          lend  <= (off_rd > 21'(LIST_DEPTH)) ? 21'(LIST_DEPTH) : off_rd;
          state <= S_WALK;
        end
        S_WALK: begin
          if (j >= lend) state <= S_DONE;
          else state <= S_LIST_CHK;
        end
        S_LIST_CHK: begin
          if (16'(list_rd) < tn) begin
            tw    <= list_rd[WORD_AW+TW_AW-1:WORD_AW];
            tbit  <= list_rd[WORD_AW-1:0];
            state <= S_TGT_UPD;
          end else begin
            j     <= j + 21'd1;
            state <= S_WALK;
          end
        end
        S_TGT_UPD: begin
          j     <= j + 21'd1;
          state <= S_WALK;
        end
        S_CNT_RD: begin
          if (sweep_base >= tn_p) state <= S_PAD_GO;
          else state <= S_CNT_ACC;
        end
        S_CNT_ACC: begin
          ones  <= ones + 16'($countones(tgt_rd & below_mask(sweep_base, tn_p)));
          sweep <= sweep + (CLR_AW+1)'(1);
          state <= S_CNT_RD;
        end
        S_PAD_GO: begin
          need  <= PAD_W'(0) - ones[PAD_W-1:0];
          pos   <= POS_W'(cfg.first_count);
          state <= S_PAD_RD;
        end
        S_PAD_RD: begin
          if (pos >= tn_p || need == '0) begin
            sel_total          <= ones;
            cursor             <= '0;
            res.selected_count <= ones;
            state              <= S_DONE;
          end else begin
            tw    <= pos[WORD_AW+TW_AW-1:WORD_AW];
            state <= S_PAD_CHK;
          end
        end
        S_PAD_CHK: begin
          if (elig != '0) begin
            ones <= ones + 16'd1;
            need <= need - PAD_W'(1);
            pos  <= POS_W'({tw, elig_b}) + POS_W'(1);
          end else begin
            pos  <= POS_W'({tw, WORD_AW'(0)}) + POS_W'(WORD_W);
          end
          state <= S_PAD_RD;
        end
        S_SCAN: begin
          if (pos >= tn_p) begin
            res.selected_count <= sel_total;
            if (phase) begin
              res.selected_index <= kfound;
              res.last           <= 1'b1;
              cursor             <= 16'(kfound) + 16'd1;
            end else begin
              res.status <= ST_NO_MORE;
              if (cursor < tn) cursor <= tn;
            end
            state <= S_DONE;
          end else begin
            tw    <= pos[WORD_AW+TW_AW-1:WORD_AW];
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (scan_m != '0) begin
            if (phase) begin
              res.selected_count <= sel_total;
              res.selected_index <= kfound;
              cursor             <= 16'(kfound) + 16'd1;
              state              <= S_DONE;
            end else begin
              kfound <= {tw, scan_b};
              phase  <= 1'b1;
              pos    <= POS_W'({tw, scan_b}) + POS_W'(1);
              state  <= S_SCAN;
            end
          end else begin
            pos   <= POS_W'({tw, WORD_AW'(0)}) + POS_W'(WORD_W);
            state <= S_SCAN;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/bitmap_vocab_shortlist_select.sv =====
// Top level of the bitmap vocabulary shortlist selector.
// Holds the configuration registers; depends on bvs_pkg and bvs_seq.
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes first_count,
//    shared_mode, src_vocab_size and trg_vocab_size; cfg_ready is always high.
//    Write only while no transaction is in flight.
//  - Input transactions (in_valid/in_stall, in_data) carry one action each; every
//    action returns exactly one output transaction (out_valid/out_stall, out_data).
//  - Actions step through the bitmaps one 32-bit word at a time. Load offset and load
//    list entry write one table entry if in range; begin writes one bitmap word per cycle;
//    source word ends at the range check if out of range, at the seen check if
//    already seen, else reads its two offsets and walks its list entries, setting
//    the target bit of each entry in range; finish reads each bitmap word in use,
//    then pads bit by bit, skipping words with no free bit; read next visits bitmap
//    words up to the one holding the following selected index or the target range end.
//  - One action is in work at a time; in_stall is high until its result is
//    registered. A result waiting on out_stall holds out_data; the next action is
//    accepted meanwhile and its result waits until the output register frees.
//  - Reset: synchronous rst restores the register defaults and runs a clearing pass
//    over both bitmaps, with in_stall high.
module bitmap_vocab_shortlist_select (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bvs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bvs_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import bvs_pkg::*;

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_count    <= 16'd100;
      cfg.shared_mode    <= 1'b0;
      cfg.src_vocab_size <= 16'd32768;
      cfg.trg_vocab_size <= 16'd32768;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRST_COUNT: cfg.first_count    <= cfg_data;
        CFG_SHARED_MODE: cfg.shared_mode    <= cfg_data[0];
        CFG_SRC_SIZE:    cfg.src_vocab_size <= cfg_data;
        CFG_TRG_SIZE:    cfg.trg_vocab_size <= cfg_data;
        default: ;
      endcase
    end
  end

  bvs_seq u_seq (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

// ===== src/bvs_checker.sv =====
// Port-level checker for the shortlist selector, bound to the top level.
// Depends on bvs_pkg.
module bvs_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input bvs_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input bvs_pkg::out_t out_data,
  input logic          cfg_valid,
  input logic          cfg_ready,
  input logic [7:0]    cfg_index,
  input logic [15:0]   cfg_data
);
  import bvs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_clear_stall: assert property (@(posedge clk)
    $past(rst) |-> in_stall)
    else $error("input taken during clearing pass");

  a_last_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.status == ST_OK)
    else $error("last flagged on a failed transaction");

  a_no_more: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_NO_MORE |->
      out_data.selected_index == 15'd0 && !out_data.last)
    else $error("exhausted read carries an index");

endmodule

bind bitmap_vocab_shortlist_select bvs_checker u_bvs_checker (.*);
